// ===== rtl/stpg_pkg.sv =====
// Shared types, constants and helpers for the trapezoid step pulse generator.
// Used by stpg_ctrl, stpg_dpath and the top level; no dependencies.
package stpg_pkg;

   localparam int WidthW = 16;                 // pulse half-period and counts
   localparam int RampW  = 10;                 // ramp lengths and ramp index
   localparam int ProdW  = WidthW + RampW;     // diff * ramp index
   localparam int CsrIdxW  = 2;
   localparam int DivSteps = WidthW;           // quotient always fits WidthW bits
   localparam int DivCntW  = $clog2(DivSteps);

   localparam logic [WidthW-1:0] StartWidthRst = WidthW'(200);
   localparam logic [WidthW-1:0] MinWidthRst   = WidthW'(6);
   localparam logic [RampW-1:0]  AccelRst      = RampW'(30);
   localparam logic [RampW-1:0]  DecelRst      = RampW'(30);
   localparam logic [RampW-1:0]  RampMax       = '1;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrStartWidth = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMinWidth   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrAccelSteps = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrDecelSteps = 2'd3;

   // move phases
   localparam logic [1:0] PhIdle   = 2'd0;
   localparam logic [1:0] PhAccel  = 2'd1;
   localparam logic [1:0] PhCruise = 2'd2;
   localparam logic [1:0] PhDecel  = 2'd3;

   // request function codes
   localparam logic FuncTick  = 1'b0;
   localparam logic FuncStart = 1'b1;

   typedef struct packed {
      logic accept;     // take the request word and update the move state
      logic prep;       // start the width computation for the new pulse
      logic div_step;   // one quotient bit
      logic finish;     // load the divided width
   } ctrl_cmd_type;

   typedef struct packed {
      logic begin_pulse;  // the request word would start a new pulse
      logic need_div;     // the new pulse sits on a ramp
      logic out_hold;     // result word waiting and stalled
   } dp_status_type;

   // a width of zero runs as one tick
   function automatic logic [WidthW-1:0] nonzero_width(input logic [WidthW-1:0] w);
      return (w == '0) ? WidthW'(1) : w;
   endfunction

endpackage

// ===== rtl/stpg_ctrl.sv =====
// Sequencer of the step pulse generator: accepts request words and steps the
// width divider. Depends on stpg_pkg.
module stpg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  stpg_pkg::dp_status_type status,
   output logic                   req_stall,
   output stpg_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] SIdle = 2'd0;
   localparam logic [1:0] SPrep = 2'd1;
   localparam logic [1:0] SDiv  = 2'd2;
   localparam logic [1:0] SFin  = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [stpg_pkg::DivCntW-1:0]   cnt_ff, cnt_in;
   logic                           ready;

   assign ready     = (state_ff == SIdle) && !status.out_hold;
   assign req_stall = !ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         SIdle: begin
            cmd.accept = req_valid && ready;
            if (cmd.accept && status.begin_pulse) begin
               state_in = SPrep;
            end
         end
         SPrep: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = status.need_div ? SDiv : SIdle;
         end
         SDiv: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == stpg_pkg::DivCntW'(stpg_pkg::DivSteps - 1)) begin
               state_in = SFin;
            end
         end
         SFin: begin
            cmd.finish = 1'b1;
            state_in   = SIdle;
         end
         default: begin
            state_in = SIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/stpg_dpath.sv =====
// Datapath of the step pulse generator: config registers, move state, ramp
// width multiply and restoring divider, result register. Depends on stpg_pkg.
module stpg_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stpg_pkg::ctrl_cmd_type                cmd,
   output stpg_pkg::dp_status_type               status,
   input  logic                                  csr_write,
   input  logic [stpg_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [stpg_pkg::WidthW-1:0]           csr_data,
   input  logic                                  req_func,
   input  logic [stpg_pkg::WidthW-1:0]           req_step_count,
   input  logic                                  req_move_direction,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_step_level,
   output logic                                  rsp_dir_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_move_done,
   output logic                                  rsp_start_refused
);

   localparam int W = stpg_pkg::WidthW;
   localparam int R = stpg_pkg::RampW;

   // configuration
   logic [W-1:0] start_width_ff, min_width_ff;
   logic [R-1:0] accel_ff, decel_ff;

   // move state
   logic [1:0]   phase_ff, phase_in;
   logic [R-1:0] ri_ff, ri_in;
   logic [W-1:0] steps_ff, steps_in;
   logic [W-1:0] cruise_ff, cruise_in;
   logic [W-1:0] width_ff;
   logic [W-1:0] tick_ff, tick_in;
   logic         pin_ff, pin_in;
   logic         dir_ff, dir_in;

   // divider
   logic [R-1:0] rem_ff;
   logic [W-1:0] quo_ff;
   logic [R-1:0] div_ff;

   // result register
   logic         rsp_valid_ff;
   logic         step_ff, busy_ff, done_ff, refused_ff, dir_out_ff;

   logic         step_o, busy_o, done_o, refused_o, bp;
   logic [R:0]   ramps;
   logic [W-1:0] start_cruise, tick_inc, steps_dec, cruise_dec;
   logic [R-1:0] ri_inc;

   logic [W-1:0] diff;
   logic [W-1:0] direct_w;
   logic [R-1:0] k_fac, divisor;
   logic         need_div;
   logic [stpg_pkg::ProdW-1:0] prod;
   logic [R:0]   shifted;
   logic         ge;

   assign ramps        = {1'b0, accel_ff} + {1'b0, decel_ff};
   assign start_cruise = (req_step_count > W'(ramps)) ? req_step_count - W'(ramps) : '0;
   assign tick_inc     = tick_ff + W'(1);
   assign steps_dec    = (steps_ff != '0) ? steps_ff - W'(1) : steps_ff;
   assign cruise_dec   = (cruise_ff != '0) ? cruise_ff - W'(1) : cruise_ff;
   assign ri_inc       = (ri_ff < stpg_pkg::RampMax) ? ri_ff + R'(1) : ri_ff;

   // move state update for the offered request word
   always_comb begin
      phase_in  = phase_ff;
      ri_in     = ri_ff;
      steps_in  = steps_ff;
      cruise_in = cruise_ff;
      tick_in   = tick_ff;
      pin_in    = pin_ff;
      dir_in    = dir_ff;
      step_o    = 1'b0;
      busy_o    = 1'b0;
      done_o    = 1'b0;
      refused_o = 1'b0;
      bp        = 1'b0;
      if (req_func == stpg_pkg::FuncStart) begin
         if (phase_ff != stpg_pkg::PhIdle) begin
            refused_o = 1'b1;
            busy_o    = 1'b1;
            step_o    = pin_ff;
         end else begin
            dir_in = req_move_direction;
            if (req_step_count != '0) begin
               cruise_in = start_cruise;
               steps_in  = req_step_count;
               ri_in     = '0;
               if (accel_ff != '0) begin
                  phase_in = stpg_pkg::PhAccel;
               end else begin
                  phase_in = (start_cruise != '0) ? stpg_pkg::PhCruise : stpg_pkg::PhDecel;
               end
               bp     = 1'b1;
               busy_o = 1'b1;
            end
         end
      end else if (phase_ff != stpg_pkg::PhIdle) begin
         step_o = pin_ff;
         busy_o = 1'b1;
         if (tick_inc >= width_ff) begin
            tick_in = '0;
            if (pin_ff) begin
               pin_in = 1'b0;
            end else begin
               steps_in = steps_dec;
               if (steps_dec == '0) begin
                  phase_in  = stpg_pkg::PhIdle;
                  ri_in     = '0;
                  cruise_in = '0;
                  done_o    = 1'b1;
               end else begin
                  bp = 1'b1;
                  case (phase_ff)
                     stpg_pkg::PhAccel: begin
                        ri_in = ri_inc;
                        if (ri_inc >= accel_ff) begin
                           ri_in    = '0;
                           phase_in = (cruise_ff != '0) ? stpg_pkg::PhCruise
                                                        : stpg_pkg::PhDecel;
                        end
                     end
                     stpg_pkg::PhCruise: begin
                        cruise_in = cruise_dec;
                        if (cruise_dec == '0) begin
                           phase_in = stpg_pkg::PhDecel;
                           ri_in    = '0;
                        end
                     end
                     default: begin
                        ri_in = ri_inc;
                     end
                  endcase
               end
            end
         end else begin
            tick_in = tick_inc;
         end
      end
      if (bp) begin
         tick_in = '0;
         pin_in  = 1'b1;
      end
   end

   // width of the new pulse, from the registered phase and ramp index
   assign diff = (start_width_ff > min_width_ff) ? start_width_ff - min_width_ff : '0;

   always_comb begin
      case (phase_ff)
         stpg_pkg::PhAccel: begin
            need_div = ri_ff < accel_ff;
            k_fac    = ri_ff;
            divisor  = accel_ff;
            direct_w = start_width_ff - diff;
         end
         stpg_pkg::PhDecel: begin
            need_div = ri_ff < decel_ff;
            k_fac    = decel_ff - R'(1) - ri_ff;
            divisor  = decel_ff;
            direct_w = start_width_ff;
         end
         default: begin
            need_div = 1'b0;
            k_fac    = '0;
            divisor  = decel_ff;
            direct_w = min_width_ff;
         end
      endcase
   end

   assign prod    = {{R{1'b0}}, diff} * {{W{1'b0}}, k_fac};
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign ge      = shifted >= {1'b0, div_ff};

   assign status.begin_pulse = bp;
   assign status.need_div    = need_div;
   assign status.out_hold    = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_width_ff <= stpg_pkg::StartWidthRst;
         min_width_ff   <= stpg_pkg::MinWidthRst;
         accel_ff       <= stpg_pkg::AccelRst;
         decel_ff       <= stpg_pkg::DecelRst;
      end else if (csr_write) begin
         case (csr_index)
            stpg_pkg::CsrStartWidth: start_width_ff <= csr_data;
            stpg_pkg::CsrMinWidth:   min_width_ff   <= csr_data;
            stpg_pkg::CsrAccelSteps: accel_ff       <= csr_data[R-1:0];
            stpg_pkg::CsrDecelSteps: decel_ff       <= csr_data[R-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= stpg_pkg::PhIdle;
         ri_ff        <= '0;
         steps_ff     <= '0;
         cruise_ff    <= '0;
         width_ff     <= '0;
         tick_ff      <= '0;
         pin_ff       <= 1'b0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.accept || (rsp_valid_ff && rsp_stall);
         if (cmd.accept) begin
            phase_ff  <= phase_in;
            ri_ff     <= ri_in;
            steps_ff  <= steps_in;
            cruise_ff <= cruise_in;
            tick_ff   <= tick_in;
            pin_ff    <= pin_in;
            dir_ff    <= dir_in;
         end
         if (cmd.prep && !need_div) begin
            width_ff <= stpg_pkg::nonzero_width(direct_w);
         end
         if (cmd.finish) begin
            width_ff <= stpg_pkg::nonzero_width(start_width_ff - quo_ff);
         end
      end
   end

   // quotient fits W bits, so the top R product bits are already below the divisor
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff <= prod[stpg_pkg::ProdW-1:W];
         quo_ff <= prod[W-1:0];
         div_ff <= divisor;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? R'(shifted - {1'b0, div_ff}) : shifted[R-1:0];
         quo_ff <= {quo_ff[W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         step_ff    <= step_o;
         busy_ff    <= busy_o;
         done_ff    <= done_o;
         refused_ff <= refused_o;
         dir_out_ff <= dir_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_level    = step_ff;
   assign rsp_dir_level     = dir_out_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_move_done     = done_ff;
   assign rsp_start_refused = refused_ff;

endmodule

// ===== rtl/stepper_trapezoid_pulse_generator.sv =====
// Trapezoid step pulse generator, top level.
// Instantiates stpg_ctrl and stpg_dpath; uses stpg_pkg.
//
// Usage:
//  - req channel: one word per timer tick (func = tick) or a move start
//    (func = start, with step_count and move_direction). Every word gives
//    exactly one rsp word with the pin levels and status flags for it.
//  - csr port: start width, min width, accel length, decel length at indexes
//    0..3; write only while no word is in flight.
//  - Latency: the rsp word is valid the cycle after the req word is taken.
//  - Pacing: a word that does not begin a new pulse leaves the block ready for the
//    next word. A word that begins a cruise pulse, or one past the end of a ramp,
//    first runs a width load step; a word that begins a ramp pulse runs a multiply
//    step, 16 steps of the one-bit-per-cycle restoring divider, and a load step.
//  - Reset: registers return to 200/6/30/30, the block is idle, rsp_valid low.
//  - A stalled rsp word holds; req_stall stays high until it is taken, after
//    which the next req word can be taken in the same cycle.
module stepper_trapezoid_pulse_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [stpg_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [stpg_pkg::WidthW-1:0]           csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [stpg_pkg::WidthW-1:0]           req_step_count,
   input  logic                                  req_move_direction,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_step_level,
   output logic                                  rsp_dir_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_move_done,
   output logic                                  rsp_start_refused
);

   stpg_pkg::ctrl_cmd_type  cmd;
   stpg_pkg::dp_status_type status;

   stpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   stpg_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_func           (req_func),
      .req_step_count     (req_step_count),
      .req_move_direction (req_move_direction),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_step_level     (rsp_step_level),
      .rsp_dir_level      (rsp_dir_level),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_move_done      (rsp_move_done),
      .rsp_start_refused  (rsp_start_refused)
   );

`ifndef SYNTHESIS
   // every accepted word shows up as a result word on the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted word produced no result");

   a_refused_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_start_refused) |-> (rsp_busy_res && !rsp_move_done))
      else $error("refused start without busy");

   // a move ends only at the end of a low half-period
   a_done_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_done) |-> (rsp_busy_res && !rsp_step_level))
      else $error("move done with step pin high");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_stall && !rsp_valid))
      else $error("not ready after reset");
`endif

endmodule
